@@ rtl/bsn_pkg.sv @@
//------------------------------------------------------------------------------
// bsn_pkg
// Shared widths, codes and types of the bus sensor node responder.
//------------------------------------------------------------------------------
`default_nettype none

package bsn_pkg;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int SENSOR_W = 16;
	localparam int SAMPLE_W = 15;
	localparam int ANGLE_W  = 21;
	localparam int ID_W     = 5;
	localparam int IVL_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int SEQ_W    = 3;

	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [SENSOR_W-1:0]  sensor_t;
	typedef logic [ANGLE_W-1:0]   angle_t;
	typedef logic [ID_W-1:0]      node_id_t;
	typedef logic [IVL_W-1:0]     ticks_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [SEQ_W-1:0]     seq_t;

	localparam cmd_t CMD_BUS_BYTE = 2'd0;
	localparam cmd_t CMD_SAMPLE   = 2'd1;
	localparam cmd_t CMD_TICK     = 2'd2;

	localparam logic KIND_TX      = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam cfg_idx_t REG_NODE_ID       = 2'd0;
	localparam cfg_idx_t REG_READ_INTERVAL = 2'd1;

	localparam node_id_t NODE_ID_RST   = 5'd1;
	localparam ticks_t   INTERVAL_RST  = 8'd20;
	localparam ticks_t   TICKS_MAX     = 8'hFF;

	localparam logic [1:0] PKT_QUERY   = 2'd1;
	localparam logic [1:0] PKT_RELAY   = 2'd2;

	localparam seq_t SEQ_REQUEST = 3'd4;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LOW    = 4'b0010,
		PH_MID    = 4'b0100,
		PH_HIGH   = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

@@ rtl/bsn_req_if.sv @@
//------------------------------------------------------------------------------
// bsn_req_if
// Input item channel: command, bus byte and sensor word.
//------------------------------------------------------------------------------
`default_nettype none

interface bsn_req_if;
	logic                valid;
	logic                ready;
	bsn_pkg::cmd_t       cmd;
	bsn_pkg::byte_t      rx_byte;
	bsn_pkg::sensor_t    sensor_word;

	modport source (output valid, output cmd, output rx_byte, output sensor_word,
		input ready);
	modport sink (input valid, input cmd, input rx_byte, input sensor_word,
		output ready);
endinterface

`default_nettype wire

@@ rtl/bsn_rsp_if.sv @@
//------------------------------------------------------------------------------
// bsn_rsp_if
// Result item channel: transmit byte or sensor read request.
//------------------------------------------------------------------------------
`default_nettype none

interface bsn_rsp_if;
	logic           valid;
	logic           ready;
	logic           out_kind;
	bsn_pkg::byte_t tx_byte;
	logic           last_of_run;

	modport source (output valid, output out_kind, output tx_byte, output last_of_run,
		input ready);
	modport sink (input valid, input out_kind, input tx_byte, input last_of_run,
		output ready);
endinterface

`default_nettype wire

@@ rtl/bsn_cfg_if.sv @@
//------------------------------------------------------------------------------
// bsn_cfg_if
// Configuration write channel: register index and write data.
//------------------------------------------------------------------------------
`default_nettype none

interface bsn_cfg_if;
	logic               valid;
	logic               ready;
	bsn_pkg::cfg_idx_t  index;
	bsn_pkg::byte_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/bus_sensor_node_responder.sv @@
//------------------------------------------------------------------------------
// bus_sensor_node_responder
// Bus packet deframer and reply generator with periodic sensor read requests.
//------------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  req     | in  | cmd, rx_byte, sensor_word                | valid/ready
//  rsp     | out | out_kind, tx_byte, last_of_run           | valid/ready
//  cfg     | in  | index (0 node_id, 1 read_interval), data | valid/ready
//
//  An item's state update lands at the edge at which it is taken.
//  A tick request gives one result, an answered packet five, one per cycle while rsp.ready is high.
//  req.ready is high when the result register is empty or its last result
//  is being taken, so items without results stream at one per cycle.
//  arst_n clears parser, angle and result register and sets the tick counter to its maximum.
//------------------------------------------------------------------------------
`default_nettype none

module bus_sensor_node_responder (
	input  wire logic clk,
	input  wire logic arst_n,
	bsn_req_if.sink   req,
	bsn_rsp_if.source rsp,
	bsn_cfg_if.sink   cfg
);
	import bsn_pkg::*;

	node_id_t node_id_q;
	ticks_t   interval_q;
	phase_t   phase_q;
	logic [6:0] hdr_q;
	angle_t   angle_q;
	ticks_t   ticks_q;

	logic     valid_s1;
	logic     reply_s1;
	byte_t    head_s1;
	angle_t   angle_s1;
	seq_t     seq_s1;

	logic     in_fire;
	logic     out_fire;
	logic     out_last;
	logic     high;
	logic [ID_W-1:0] pkt_id;
	logic [1:0] pkt_c;
	node_id_t prev_id;
	logic     answer;
	ticks_t   ticks_inc;
	logic     tick_req;
	logic     load;
	logic     load_reply;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= NODE_ID_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NODE_ID:       node_id_q  <= cfg.data[ID_W-1:0];
				REG_READ_INTERVAL: interval_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign out_last  = (!reply_s1) || (seq_s1 == SEQ_REQUEST);
	assign out_fire  = valid_s1 && rsp.ready;
	assign req.ready = !valid_s1 || (rsp.ready && out_last);
	assign in_fire   = req.valid && req.ready;

	assign high      = req.rx_byte[7];
	assign pkt_id    = hdr_q[6:2];
	assign pkt_c     = hdr_q[1:0];
	assign prev_id   = node_id_q - ID_W'(1);
	assign answer    = (pkt_id == node_id_q) ? (pkt_c == PKT_QUERY)
		: ((pkt_id == prev_id) && (pkt_c == PKT_RELAY));
	assign ticks_inc = (ticks_q == TICKS_MAX) ? TICKS_MAX : ticks_q + IVL_W'(1);
	assign tick_req  = (ticks_inc >= interval_q);

	always_comb begin
		load_reply = 1'b0;
		load       = 1'b0;
		case (req.cmd)
			CMD_BUS_BYTE: begin
				load_reply = (phase_q == PH_HIGH) && !high && answer;
				load       = load_reply;
			end
			CMD_TICK: load = tick_req;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			angle_q <= '0;
			ticks_q <= TICKS_MAX;
		end else if (in_fire) begin
			case (req.cmd)
				CMD_BUS_BYTE: begin
					case (phase_q)
						PH_HEADER: begin
							if (high) begin
								hdr_q   <= req.rx_byte[6:0];
								phase_q <= PH_LOW;
							end
						end
						PH_LOW:  phase_q <= high ? PH_HEADER : PH_MID;
						PH_MID:  phase_q <= high ? PH_HEADER : PH_HIGH;
						default: phase_q <= PH_HEADER;
					endcase
					if (load_reply) begin
						ticks_q <= '0;
					end
				end
				CMD_SAMPLE: angle_q <= {req.sensor_word[SAMPLE_W-1:0],
					req.sensor_word[SAMPLE_W-1:9]};
				CMD_TICK: ticks_q <= tick_req ? '0 : ticks_inc;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			reply_s1 <= 1'b0;
			seq_s1   <= '0;
		end else if (in_fire && load) begin
			valid_s1 <= 1'b1;
			reply_s1 <= load_reply;
			seq_s1   <= load_reply ? '0 : SEQ_REQUEST;
		end else if (out_fire) begin
			if (out_last) begin
				valid_s1 <= 1'b0;
			end else begin
				seq_s1 <= seq_s1 + SEQ_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && load_reply) begin
			head_s1  <= {1'b1, node_id_q, pkt_c};
			angle_s1 <= angle_q;
		end
	end

	always_comb begin
		rsp.out_kind = KIND_TX;
		rsp.tx_byte  = '0;
		case (seq_s1)
			3'd0: rsp.tx_byte = head_s1;
			3'd1: rsp.tx_byte = {1'b0, angle_s1[6:0]};
			3'd2: rsp.tx_byte = {1'b0, angle_s1[13:7]};
			3'd3: rsp.tx_byte = {1'b0, angle_s1[20:14]};
			default: rsp.out_kind = KIND_REQUEST;
		endcase
	end

	assign rsp.valid       = valid_s1;
	assign rsp.last_of_run = out_last;

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (!valid_s1 || (rsp.ready && out_last)))
		else $error("item taken while a result run is still pending");

	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (seq_s1 <= SEQ_REQUEST))
		else $error("result sequence out of range");

	a_request_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (rsp.out_kind == KIND_REQUEST)) |-> rsp.last_of_run)
		else $error("read request not at end of run");

	a_request_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && load) |=> (ticks_q == '0))
		else $error("tick counter not cleared by read request");

endmodule

`default_nettype wire

@@ test/bus_sensor_node_responder_test.sv @@
//------------------------------------------------------------------------------
// bus_sensor_node_responder_test
// Drives bus bytes, sensor samples and ticks into the responder under
// several node addresses, read intervals and idle patterns. Every accepted
// item runs through a cycle-free copy of the node's behavior, and each
// result taken from the block is compared against the oldest expected one.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_sensor_node_responder_test;
	import bsn_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;
	localparam int PHASE_ITEMS  = 24;

	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic  kind;
		byte_t tx;
		logic  last;
	} reply_t;

	class reply_tracker;
		node_id_t   node_id;
		ticks_t     interval;
		phase_t     phase;
		logic [6:0] header;
		angle_t     angle;
		ticks_t     ticks;
		logic       read_pending;
		reply_t     run[$];
		reply_t     replies_due[$];
		int         mismatch_count;

		function new();
			node_id        = NODE_ID_RST;
			interval       = INTERVAL_RST;
			phase          = PH_HEADER;
			header         = '0;
			angle          = '0;
			ticks          = TICKS_MAX;
			read_pending   = 1'b0;
			mismatch_count = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, byte_t value);
			if (idx == REG_NODE_ID) begin
				node_id = value[ID_W-1:0];
			end else if (idx == REG_READ_INTERVAL) begin
				interval = value;
			end
		endfunction

		function void add_tx(byte_t value);
			run.push_back('{kind: KIND_TX, tx: value, last: 1'b0});
		endfunction

		function void add_request();
			run.push_back('{kind: KIND_REQUEST, tx: 8'h00, last: 1'b0});
			read_pending = 1'b1;
			ticks        = '0;
		endfunction

		function void parse_byte(byte_t b);
			node_id_t   id;
			node_id_t   prev;
			logic [1:0] code;
			case (phase)
			PH_HEADER: begin
				if (b[7]) begin
					header = b[6:0];
					phase  = PH_LOW;
				end
			end
			PH_LOW: phase = b[7] ? PH_HEADER : PH_MID;
			PH_MID: phase = b[7] ? PH_HEADER : PH_HIGH;
			default: begin
				phase = PH_HEADER;
				id    = header[6:2];
				code  = header[1:0];
				prev  = node_id - 1'b1;
				if (!b[7] && ((id == node_id && code == PKT_QUERY) ||
						(id == prev && code == PKT_RELAY))) begin
					add_tx({1'b1, node_id, code});
					add_tx({1'b0, angle[6:0]});
					add_tx({1'b0, angle[13:7]});
					add_tx({1'b0, angle[20:14]});
					add_request();
				end
			end
			endcase
		endfunction

		function void take_item(cmd_t c, byte_t b, sensor_t w);
			run.delete();
			case (c)
			CMD_BUS_BYTE: parse_byte(b);
			CMD_SAMPLE: begin
				angle        = {w[SAMPLE_W-1:0], w[SAMPLE_W-1:SAMPLE_W-6]};
				read_pending = 1'b0;
			end
			CMD_TICK: begin
				if (ticks != TICKS_MAX) begin
					ticks = ticks + 1'b1;
				end
				if (ticks >= interval) begin
					add_request();
				end
			end
			default: ;
			endcase
			if (run.size() > 0) begin
				run[run.size()-1].last = 1'b1;
			end
			foreach (run[i]) begin
				replies_due.push_back(run[i]);
			end
		endfunction

		function void flag(string msg);
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endfunction

		function void match_reply(logic kind, byte_t tx, logic last);
			reply_t due;
			if (replies_due.size() == 0) begin
				flag($sformatf("unexpected result kind=%0d tx=%02h last=%0d",
					kind, tx, last));
				return;
			end
			due = replies_due.pop_front();
			if (kind !== due.kind || tx !== due.tx || last !== due.last) begin
				flag($sformatf("expected kind=%0d tx=%02h last=%0d, got kind=%0d tx=%02h last=%0d",
					due.kind, due.tx, due.last, kind, tx, last));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bsn_req_if req();
	bsn_rsp_if rsp();
	bsn_cfg_if cfg();

	reply_tracker tracker;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycles = 0;

	bus_sensor_node_responder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bus_sensor_node_responder verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready === 1'b1) begin
				tracker.set_reg(cfg.index, cfg.data);
			end
			if (rsp.valid === 1'b1 && rsp.ready) begin
				tracker.match_reply(rsp.out_kind, rsp.tx_byte, rsp.last_of_run);
			end
			if (req.valid && req.ready === 1'b1) begin
				tracker.take_item(req.cmd, req.rx_byte, req.sensor_word);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp.ready = 1'b0;
			hold_left--;
		end else begin
			rsp.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input cmd_t c, input byte_t b, input sensor_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid       = 1'b1;
		req.cmd         = c;
		req.rx_byte     = b;
		req.sensor_word = w;
		do @(posedge clk); while (req.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_frame(input byte_t hdr, input byte_t d0, input byte_t d1,
			input byte_t d2);
		send_item(CMD_BUS_BYTE, hdr, sensor_t'($urandom));
		send_item(CMD_BUS_BYTE, d0, sensor_t'($urandom));
		send_item(CMD_BUS_BYTE, d1, sensor_t'($urandom));
		send_item(CMD_BUS_BYTE, d2, sensor_t'($urandom));
	endtask

	task automatic write_reg(input cfg_idx_t idx, input byte_t value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic configure(input node_id_t node, input ticks_t ivl);
		write_reg(REG_NODE_ID, {3'($urandom_range(7)), node});
		write_reg(REG_READ_INTERVAL, ivl);
		cfg.valid = 1'b0;
	endtask

	task automatic settle();
		req.valid = 1'b0;
		while (tracker.replies_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_directed();
		send_item(CMD_TICK, 8'h00, 16'h0000);
		send_item(CMD_SAMPLE, 8'hFF, 16'h7FFF);
		send_frame({1'b1, NODE_ID_RST, PKT_QUERY}, 8'h00, 8'h7F, 8'h55);
		send_item(CMD_SAMPLE, 8'h00, 16'h8000);
		send_frame({1'b1, NODE_ID_RST - 5'd1, PKT_RELAY}, 8'h00, 8'h00, 8'h00);
		send_frame({1'b1, NODE_ID_RST, PKT_RELAY}, 8'h12, 8'h34, 8'h56);
		send_item(CMD_SAMPLE, 8'h00, 16'h2AD5);
		// drop on header bit in a data slot, then on a data byte with no header
		send_item(CMD_BUS_BYTE, {1'b1, NODE_ID_RST, PKT_QUERY}, 16'hFFFF);
		send_item(CMD_BUS_BYTE, 8'hFF, 16'h0000);
		send_item(CMD_BUS_BYTE, 8'h05, 16'h0000);
		send_frame({1'b1, NODE_ID_RST, PKT_QUERY}, 8'h11, 8'h22, 8'h93);
		send_frame({1'b1, NODE_ID_RST, PKT_QUERY}, 8'h01, 8'h02, 8'h03);
		send_item(CMD_UNUSED, 8'hFF, 16'hFFFF);
	endtask

	task automatic send_random(input int n);
		int         count;
		int         pick;
		int         cut;
		node_id_t   id;
		logic [1:0] code;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					id = tracker.node_id;
				end else if (pick < 75) begin
					id = tracker.node_id - 1'b1;
				end else begin
					id = node_id_t'($urandom_range(31));
				end
				code = 2'($urandom_range(3));
				if ($urandom_range(1) == 1) begin
					code = (id == tracker.node_id) ? PKT_QUERY : PKT_RELAY;
				end
				send_item(CMD_BUS_BYTE, {1'b1, id, code}, sensor_t'($urandom));
				cut = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
				for (int k = 1; k <= 3; k++) begin
					if (k == cut) begin
						send_item(CMD_BUS_BYTE, {1'b1, 7'($urandom_range(127))},
							sensor_t'($urandom));
					end else begin
						send_item(CMD_BUS_BYTE, {1'b0, 7'($urandom_range(127))},
							sensor_t'($urandom));
					end
				end
				count += 4;
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4)) begin
					send_item(CMD_TICK, byte_t'($urandom), sensor_t'($urandom));
					count++;
				end
			end else if (pick < 85) begin
				send_item(CMD_SAMPLE, byte_t'($urandom), sensor_t'($urandom));
				count++;
			end else if (pick < 95) begin
				send_item(CMD_BUS_BYTE, byte_t'($urandom), sensor_t'($urandom));
				count++;
			end else begin
				send_item(CMD_UNUSED, byte_t'($urandom), sensor_t'($urandom));
			end
		end
	endtask

	initial begin
		tracker         = new();
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.cmd         = CMD_BUS_BYTE;
		req.rx_byte     = '0;
		req.sensor_word = '0;
		rsp.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_NODE_ID;
		cfg.data        = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_left       = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		settle();

		configure(5'd0, 8'd1);
		hold_left = HOLD_CYCLES;
		send_random(PHASE_ITEMS);
		settle();

		configure(5'd31, 8'd255);
		send_idle_pct = 88;
		send_random(PHASE_ITEMS);
		settle();

		configure(node_id_t'($urandom_range(31)), ticks_t'($urandom_range(2, 6)));
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		send_random(PHASE_ITEMS);
		settle();

		configure(node_id_t'($urandom_range(31)), ticks_t'($urandom_range(3, 12)));
		send_idle_pct  = 14;
		recv_stall_pct = 14;
		send_random(PHASE_ITEMS);
		settle();

		if (tracker.mismatch_count == 0 && tracker.replies_due.size() == 0) begin
			$display("bus_sensor_node_responder verification clean");
		end else begin
			$display("bus_sensor_node_responder verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bsn_pkg.sv
rtl/bsn_req_if.sv
rtl/bsn_rsp_if.sv
rtl/bsn_cfg_if.sv
rtl/bus_sensor_node_responder.sv
test/bus_sensor_node_responder_test.sv
